[hw/rtl/csvp_pkg.sv]
// Shared types and constants for the CSV integer field parser.
`default_nettype none

package csvp_pkg;

  // Column limit and derived widths
  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int CFG_W       = 5;
  localparam int VAL_W       = 32;
  localparam int ROW_W       = 32;
  localparam int COL_OUT_W   = 4;

  // Configuration register indexes
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_SKIP_HEADER  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } csvp_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]     field_value;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_W-1:0]     row_index;
    logic                 padded;
    logic                 last_of_row;
  } csvp_out_t;

endpackage

`default_nettype wire

[hw/rtl/csv_integer_field_parser.sv]
// Top level of the CSV integer field parser.
`default_nettype none

// Takes one CSV text byte per transaction and returns one unsigned 32-bit
// value per configured column of each data row, with column and row number.
// A byte is parsed in the cycle it is accepted and its result lands in the
// output register, so one byte per cycle is sustained while the output side
// keeps up. When a newline or end of input closes a short row, the padding
// results are issued one per cycle from a column counter while the output
// side keeps up, and input is held off until the padding is done. Configure
// column_count and skip_header only while the block is idle.
module csv_integer_field_parser
  import csvp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire csvp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output csvp_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [CFG_W-1:0] column_count_r;
  logic             skip_header_r;

  // Stream state
  logic             header_pending_r, header_pending_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             spoiled_r, spoiled_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             line_started_r, line_started_nxt;
  logic             ignore_r, ignore_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Padding sequencer
  logic             pad_active_r, pad_active_nxt;
  logic [COL_W-1:0] pad_col_r, pad_col_nxt;
  logic [ROW_W-1:0] pad_row_r, pad_row_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  csvp_out_t        out_data_r, out_data_nxt;

  logic             slot_free;
  logic             accept;
  logic [COL_W-1:0] count;
  logic [7:0]       b;
  logic             eoi;
  logic             is_digit;
  logic [VAL_W-1:0] value;
  logic             emit;
  csvp_out_t        emit_data;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && !pad_active_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.data_byte;
  assign eoi      = in_data.end_of_input;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign value    = spoiled_r ? '0 : acc_r;

  // Clamp the configured column count to 1..MAX_COLUMNS
  always_comb begin
    priority if (column_count_r == '0) begin
      count = COL_W'(1);
    end else if (COL_W'(column_count_r) > COL_W'(MAX_COLUMNS)) begin
      count = COL_W'(MAX_COLUMNS);
    end else begin
      count = COL_W'(column_count_r);
    end
  end

  // Parse the accepted byte
  always_comb begin
    header_pending_nxt = header_pending_r;
    acc_nxt            = acc_r;
    spoiled_nxt        = spoiled_r;
    col_nxt            = col_r;
    line_started_nxt   = line_started_r;
    ignore_nxt         = ignore_r;
    row_nxt            = row_r;
    pad_active_nxt     = pad_active_r;
    pad_col_nxt        = pad_col_r;
    pad_row_nxt        = pad_row_r;
    emit               = 1'b0;
    emit_data.field_value = value;
    emit_data.column      = col_r[COL_OUT_W-1:0];
    emit_data.row_index   = row_r;
    emit_data.padded      = 1'b0;
    emit_data.last_of_row = (col_r == count - COL_W'(1));

    if (accept) begin
      if (!eoi && header_pending_r && skip_header_r) begin
        // Drop header bytes until its newline
        if (b == CH_NEWLINE) begin
          header_pending_nxt = 1'b0;
          acc_nxt            = '0;
          spoiled_nxt        = 1'b0;
          col_nxt            = '0;
          line_started_nxt   = 1'b0;
          ignore_nxt         = 1'b0;
        end
      end else if (eoi || b == CH_NEWLINE) begin
        // Close the row: last field now, padding from the sequencer
        if (line_started_r) begin
          if (!ignore_r && col_r < count) begin
            emit = 1'b1;
            if (col_r + COL_W'(1) < count) begin
              pad_active_nxt = 1'b1;
              pad_col_nxt    = col_r + COL_W'(1);
              pad_row_nxt    = row_r;
            end
          end
          row_nxt = row_r + ROW_W'(1);
        end
        acc_nxt          = '0;
        spoiled_nxt      = 1'b0;
        col_nxt          = '0;
        line_started_nxt = 1'b0;
        ignore_nxt       = 1'b0;
        if (eoi) begin
          header_pending_nxt = 1'b1;
          row_nxt            = '0;
        end else begin
          header_pending_nxt = 1'b0;
        end
      end else begin
        line_started_nxt = 1'b1;
        if (!ignore_r) begin
          priority if (b == CH_COMMA) begin
            // End the field
            acc_nxt     = '0;
            spoiled_nxt = 1'b0;
            if (col_r >= count) begin
              ignore_nxt = 1'b1;
            end else begin
              emit    = 1'b1;
              col_nxt = col_r + COL_W'(1);
              if (col_r + COL_W'(1) >= count) begin
                ignore_nxt = 1'b1;
              end
            end
          end else if (is_digit) begin
            // Accumulate value*10 + digit
            if (!spoiled_r) begin
              acc_nxt = {acc_r[VAL_W-4:0], 3'b000} + {acc_r[VAL_W-2:0], 1'b0}
                        + VAL_W'(b[3:0]);
            end
          end else if (b == CH_SPACE || b == CH_TAB) begin
            acc_nxt = acc_r;
          end else begin
            spoiled_nxt = 1'b1;
            acc_nxt     = '0;
          end
        end
      end
    end

    // Advance the padding sequencer when the output slot frees up
    if (pad_active_r && slot_free) begin
      pad_col_nxt = pad_col_r + COL_W'(1);
      if (pad_col_r == count - COL_W'(1)) begin
        pad_active_nxt = 1'b0;
      end
    end
  end

  // Load the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (pad_active_r && slot_free) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.field_value = '0;
      out_data_nxt.column      = pad_col_r[COL_OUT_W-1:0];
      out_data_nxt.row_index   = pad_row_r;
      out_data_nxt.padded      = 1'b1;
      out_data_nxt.last_of_row = (pad_col_r == count - COL_W'(1));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r   <= CFG_W'(1);
      skip_header_r    <= 1'b1;
      header_pending_r <= 1'b1;
      acc_r            <= '0;
      spoiled_r        <= 1'b0;
      col_r            <= '0;
      line_started_r   <= 1'b0;
      ignore_r         <= 1'b0;
      row_r            <= '0;
      pad_active_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      header_pending_r <= header_pending_nxt;
      acc_r            <= acc_nxt;
      spoiled_r        <= spoiled_nxt;
      col_r            <= col_nxt;
      line_started_r   <= line_started_nxt;
      ignore_r         <= ignore_nxt;
      row_r            <= row_nxt;
      pad_active_r     <= pad_active_nxt;
      out_valid_r      <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
          REG_SKIP_HEADER:  skip_header_r  <= cfg_wdata[0];
          default:          skip_header_r  <= skip_header_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pad_col_r  <= pad_col_nxt;
    pad_row_r  <= pad_row_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/csvp_checker.sv]
// Port-level checker for the CSV integer field parser, with its bind.
`default_nettype none

module csvp_checker
  import csvp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire csvp_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire csvp_out_t out_data
);

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Padding always carries a zero value
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.padded |-> out_data.field_value == '0)
    else $error("padded result with nonzero value");

  // Padding in progress holds off input
  a_pad_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.padded && !out_data.last_of_row |-> !in_ready)
    else $error("input accepted during row padding");

  // Padding runs through consecutive columns of the same row
  a_pad_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.padded && !out_data.last_of_row |=>
      out_valid && out_data.padded &&
      out_data.column == COL_OUT_W'($past(out_data.column) + 1'b1) &&
      out_data.row_index == $past(out_data.row_index))
    else $error("padding sequence broken");

endmodule

bind csv_integer_field_parser csvp_checker u_csvp_checker (.*);

`default_nettype wire

[tb/csvp_result_monitor.sv]
// Result monitor for the CSV field parser: mirrors config, predicts results, compares them.
module csvp_result_monitor
  import csvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  csvp_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  csvp_out_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               pending_results,
  output int               error_count
);

  // Mirrored configuration
  logic [4:0]  col_setting;
  logic        skip_hdr;

  // Parser state
  logic        hdr_pending;
  logic [31:0] acc;
  logic        spoiled;
  logic [4:0]  cur_col;
  logic        line_open;
  logic        skip_line;
  logic [31:0] row_num;

  csvp_out_t   expected_fields[$];
  int          errs;

  // Clamp the configured column count into 1..MAX_COLUMNS
  function automatic logic [4:0] active_cols();
    if (col_setting == 5'd0) return 5'd1;
    if (col_setting > MAX_COLUMNS) return 5'(MAX_COLUMNS);
    return col_setting;
  endfunction

  task automatic clear_line();
    acc       = '0;
    spoiled   = 1'b0;
    cur_col   = '0;
    line_open = 1'b0;
    skip_line = 1'b0;
  endtask

  // Queue one value for the current column and advance
  task automatic emit_value(input logic [31:0] val, input logic pad);
    csvp_out_t  r;
    logic [4:0] cnt;
    cnt           = active_cols();
    r.field_value = val;
    r.column      = cur_col[3:0];
    r.row_index   = row_num;
    r.padded      = pad;
    r.last_of_row = (cur_col == cnt - 5'd1);
    expected_fields.insert(expected_fields.size(), r);
    cur_col++;
    if (cur_col >= cnt) skip_line = 1'b1;
  endtask

  // Close the open field; drop it when it lies beyond the column count
  task automatic end_field(output bit emitted);
    logic [31:0] v;
    v       = spoiled ? 32'd0 : acc;
    acc     = '0;
    spoiled = 1'b0;
    if (cur_col >= active_cols()) begin
      skip_line = 1'b1;
      emitted   = 1'b0;
    end else begin
      emit_value(v, 1'b0);
      emitted = 1'b1;
    end
  endtask

  // Close the row and pad the missing columns
  task automatic close_row();
    bit emitted;
    end_field(emitted);
    if (emitted) begin
      while (cur_col < active_cols()) emit_value(32'd0, 1'b1);
    end
  endtask

  task automatic parse_byte(input csvp_in_t item);
    logic [7:0] b;
    logic       eoi;
    bit         emitted;
    b   = item.data_byte;
    eoi = item.end_of_input;
    if (!eoi && hdr_pending && skip_hdr) begin
      // drop header bytes until its newline
      if (b == CH_NEWLINE) begin
        hdr_pending = 1'b0;
        clear_line();
      end
    end else if (eoi || b == CH_NEWLINE) begin
      if (line_open) begin
        if (!skip_line) close_row();
        row_num++;
      end
      clear_line();
      if (eoi) begin
        hdr_pending = 1'b1;
        row_num     = '0;
      end else begin
        hdr_pending = 1'b0;
      end
    end else begin
      line_open = 1'b1;
      if (!skip_line) begin
        if (b == CH_COMMA) begin
          end_field(emitted);
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          if (!spoiled) acc = acc * 32'd10 + {24'd0, b - CH_ZERO};
        end else if (b == CH_SPACE || b == CH_TAB) begin
          // ignore blanks
        end else begin
          spoiled = 1'b1;
          acc     = '0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  // Watch all three ports; compare before predicting since results are registered
  always @(posedge clk) begin
    csvp_out_t want;
    if (!rst_n) begin
      col_setting = 5'd1;
      skip_hdr    = 1'b1;
      hdr_pending = 1'b1;
      row_num     = '0;
      clear_line();
      expected_fields.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMN_COUNT: col_setting = cfg_wdata;
          REG_SKIP_HEADER:  skip_hdr    = cfg_wdata[0];
          default: begin end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected transaction: value %0d column %0d row %0d",
                 out_data.field_value, out_data.column, out_data.row_index);
          errs++;
        end else begin
          want = expected_fields.pop_front();
          check_field("field_value", want.field_value, out_data.field_value);
          check_field("column", 32'(want.column), 32'(out_data.column));
          check_field("row_index", want.row_index, out_data.row_index);
          check_field("padded", 32'(want.padded), 32'(out_data.padded));
          check_field("last_of_row", 32'(want.last_of_row), 32'(out_data.last_of_row));
        end
      end
      if (in_valid && in_ready) parse_byte(in_data);
    end
    pending_results <= expected_fields.size();
    error_count     <= errs;
  end

endmodule

[tb/tb_top.sv]
// Top of the CSV field parser testbench: stimulus, idling, watchdog and verdict.
module tb_top;
  import csvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_BYTES    = 50;
  localparam int NUM_PHASES     = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  csvp_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  csvp_out_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  int               pending_results;
  int               error_count;
  int               idle_cycles = 0;
  int               bytes_sent  = 0;
  logic             quiet;

  always #1 clk = ~clk;

  csv_integer_field_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  csvp_result_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .error_count     (error_count)
  );

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side in random bursts, none once quiet
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offer one byte, with an occasional gap first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    csvp_in_t item;
    item.data_byte    = b;
    item.end_of_input = eoi;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_blank();
    send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
  endtask

  // One field: digits (short, long or the 32-bit maximum), empty, blanks, spoilers or noise
  task automatic send_field();
    int kind;
    int ndig;
    int r;
    kind = $urandom_range(0, 15);
    case (kind)
      11: begin end // empty field
      12: send_text("4294967295");
      13: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      15: repeat ($urandom_range(1, 2)) send_blank();
      default: begin
        ndig = (kind == 10) ? $urandom_range(10, 12) : $urandom_range(1, 4);
        for (int i = 0; i < ndig; i++) begin
          r = $urandom_range(0, 15);
          if (r == 0) send_blank();
          else if (r == 1 && kind == 14) send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
      end
    endcase
  endtask

  // One row of mostly short, sometimes overlong field lists
  task automatic send_row(input int eff);
    int nf;
    if ($urandom_range(0, 3) == 0) nf = $urandom_range(0, eff + 2);
    else nf = $urandom_range(1, ((eff < 4) ? eff : 4) + 1);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_byte(CH_COMMA, 1'b0);
      send_field();
    end
    if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
    else send_byte(CH_NEWLINE, 1'b0);
  endtask

  // Write both registers on back-to-back cycles
  task automatic configure(input logic [4:0] cols, input logic skip);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMN_COUNT;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= REG_SKIP_HEADER;
    cfg_wdata <= CFG_W'(skip);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drain all expected results, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [4:0] cols;
    logic       skip;
    int         eff;
    int         start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_COLUMN_COUNT;
    cfg_wdata <= '0;
    quiet     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: header, empty line, short row with empty field, spoiled and
    // extra fields, NUL and 0xFF bytes, blank-only row, end of input mid-line
    configure(5'd3, 1'b1);
    send_text("h\n\n1 2,\nx,9,8,6\n");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\n \n5");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    settle();

    // Random phases over several column counts and header settings
    for (int p = 1; p < NUM_PHASES; p++) begin
      case (p)
        1: begin cols = 5'd1;  skip = 1'b0; end
        2: begin cols = 5'd16; skip = 1'b1; end
        3: begin cols = 5'd2;  skip = 1'b0; end
        4: begin cols = 5'd0;  skip = 1'b1; end
        5: begin cols = 5'd31; skip = 1'b0; end
        default: begin
          cols = 5'($urandom_range(1, 6));
          skip = 1'($urandom_range(0, 1));
        end
      endcase
      if (p == NUM_PHASES - 1) quiet <= 1'b1;
      configure(cols, skip);
      eff   = (cols == 5'd0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_row(eff);
      // leave a wide row open so the next phase lowers the count mid-row
      if (p == 2) send_text("1,2,3,");
      else send_byte(8'($urandom_range(0, 255)), 1'b1);
      settle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/csvp_pkg.sv
hw/rtl/csv_integer_field_parser.sv
hw/rtl/csvp_checker.sv
tb/csvp_result_monitor.sv
tb/tb_top.sv
